/* rtl/core/gbts_pkg.sv */
package gbts_pkg;

  // field widths of the stream items
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 11;
  localparam int STATUS_W = 3;

  // default store size in bytes
  localparam int DEFAULT_CAPACITY = 1024;

  // requested edit action
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  // completion status reported with every result
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_BADMOVE = 3'd2,
    STAT_NODEL   = 3'd3,
    STAT_RANGE   = 3'd4
  } status_e;

  // one result item
  typedef struct packed {
    status_e               status;
    logic [POS_W-1:0]      cursor;
    logic [POS_W-1:0]      text_length;
    logic [CHAR_W-1:0]     char_out;
  } result_t;

endpackage

/* rtl/core/gap_buffer_text_store_top.sv */
// Gap buffer text store: an editable byte string of up to CAPACITY bytes with a cursor.
// Input stream: s_axis_tuser carries the action (insert, delete, move, read),
// s_axis_tdata the byte to insert and the position for move or read.
// Output stream: one result per transaction, m_axis_tdata holds the byte read,
// the text length and the cursor after the action, m_axis_tuser the status.
// Timing: an item is accepted only while the sequencer is idle. Insert, delete
// and rejected actions finish in the execute state, a read adds a wait for the
// registered memory read, and a move repeats a read then a write of the single
// text memory for every byte shifted across the gap.
// The result is then held in an output register.
// A stalled receiver holds the output register; the sequencer waits on its last
// cycle, and a new item can be accepted as soon as the result is registered.
// Reset: empty text, cursor at zero, output invalid. The text memory is not
// cleared; only bytes that were written are ever read back.
module gap_buffer_text_store_top import gbts_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_in[7:0], position[18:8], zero fill
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // char_out[7:0], text_length[18:8], cursor[29:19]
  output logic [2:0]  m_axis_tuser   // status[2:0]
);

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid, res_ready;
  result_t           res, out_q;
  logic              out_valid_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  gbts_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_action_i(action_e'(s_axis_tuser)),
    .cmd_char_i  (s_axis_tdata[7:0]),
    .cmd_pos_i   (s_axis_tdata[18:8]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  gbts_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register, free when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.cursor, out_q.text_length, out_q.char_out};
  assign m_axis_tuser  = out_q.status;

endmodule

/* rtl/core/gbts_ram.sv */
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/gbts_engine.sv */
module gbts_engine import gbts_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command side
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  action_e                     cmd_action_i,
  input  logic [CHAR_W-1:0]           cmd_char_i,
  input  logic [POS_W-1:0]            cmd_pos_i,
  // result side
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output result_t                     res_o,
  // text memory
  output logic                        mem_we_o,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr_o,
  output logic [CHAR_W-1:0]           mem_wdata_o,
  output logic                        mem_re_o,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr_o,
  input  logic [CHAR_W-1:0]           mem_rdata_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int XW = (PW > POS_W) ? PW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MWR  = 2'd2;
  localparam logic [1:0] S_RDW  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PW-1:0]     gb_q, gb_d, gf_q, gf_d;
  logic [PW-1:0]     gb_new, gf_new;
  action_e           act_q;
  logic [CHAR_W-1:0] char_q;
  logic [POS_W-1:0]  pos_q;

  logic [PW-1:0]     gap, len_now, len_new, gb_m1, gf_m1;
  logic [XW-1:0]     pos_x, gb_x, len_x, rd_idx, len_new_x, gb_new_x;
  logic              fwd, bwd, commit;
  status_e           status;
  logic [CHAR_W-1:0] char_out;

  // gap geometry
  assign gap     = gf_q - gb_q;
  assign len_now = PW'(CAPACITY) - gap;
  assign gb_m1   = gb_q - 1'b1;
  assign gf_m1   = gf_q - 1'b1;
  assign pos_x   = XW'(pos_q);
  assign gb_x    = XW'(gb_q);
  assign len_x   = XW'(len_now);
  assign fwd     = pos_x > gb_x;
  assign bwd     = pos_x < gb_x;
  assign rd_idx  = bwd ? pos_x : pos_x + XW'(gap);

  // sequencer
  always_comb begin
    state_d     = state_q;
    gb_new      = gb_q;
    gf_new      = gf_q;
    commit      = 1'b0;
    res_valid_o = 1'b0;
    status      = STAT_OK;
    char_out    = '0;
    cmd_ready_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = gb_q[AW-1:0];
    mem_wdata_o = char_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_idx[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_q)
          ACT_INSERT: begin
            res_valid_o = 1'b1;
            if (gb_q == gf_q) begin
              status = STAT_FULL;
            end else begin
              gb_new   = gb_q + 1'b1;
              mem_we_o = res_ready_i;
            end
          end
          ACT_DELETE: begin
            res_valid_o = 1'b1;
            if (gb_q == '0) begin
              status = STAT_NODEL;
            end else begin
              gb_new = gb_m1;
            end
          end
          ACT_MOVE: begin
            if (pos_x > len_x) begin
              res_valid_o = 1'b1;
              status      = STAT_BADMOVE;
            end else if (!fwd && !bwd) begin
              res_valid_o = 1'b1;
            end else begin
              // fetch the byte that crosses the gap next
              mem_re_o    = 1'b1;
              mem_raddr_o = fwd ? gf_q[AW-1:0] : gb_m1[AW-1:0];
              state_d     = S_MWR;
            end
          end
          default: begin
            if (pos_x >= len_x) begin
              res_valid_o = 1'b1;
              status      = STAT_RANGE;
            end else begin
              mem_re_o = 1'b1;
              state_d  = S_RDW;
            end
          end
        endcase
        if (res_valid_o && res_ready_i) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MWR: begin
        // land the fetched byte on the other side of the gap
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        commit      = 1'b1;
        if (fwd) begin
          mem_waddr_o = gb_q[AW-1:0];
          gb_new      = gb_q + 1'b1;
          gf_new      = gf_q + 1'b1;
        end else begin
          mem_waddr_o = gf_m1[AW-1:0];
          gb_new      = gb_m1;
          gf_new      = gf_m1;
        end
        state_d = S_EXEC;
      end
      S_RDW: begin
        res_valid_o = 1'b1;
        char_out    = mem_rdata_i;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    gb_d = commit ? gb_new : gb_q;
    gf_d = commit ? gf_new : gf_q;
  end

  // result fields after the action
  assign len_new   = PW'(CAPACITY) - (gf_new - gb_new);
  assign len_new_x = XW'(len_new);
  assign gb_new_x  = XW'(gb_new);

  always_comb begin
    res_o.char_out    = char_out;
    res_o.text_length = len_new_x[POS_W-1:0];
    res_o.cursor      = gb_new_x[POS_W-1:0];
    res_o.status      = status;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gb_q    <= '0;
      gf_q    <= PW'(CAPACITY);
    end else begin
      state_q <= state_d;
      gb_q    <= gb_d;
      gf_q    <= gf_d;
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      act_q  <= cmd_action_i;
      char_q <= cmd_char_i;
      pos_q  <= cmd_pos_i;
    end
  end

endmodule

/* rtl/core/gbts_checker.sv */
module gbts_checker import gbts_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  localparam bit CapFits = (CAPACITY < 2048);
  localparam logic [POS_W-1:0] CapLen = POS_W'(CAPACITY);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a nonzero byte only comes from a successful read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |-> m_axis_tuser == STAT_OK)
    else $error("byte returned with failing status");

  // cursor never passes the end of the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && CapFits |-> m_axis_tdata[29:19] <= m_axis_tdata[18:8])
    else $error("cursor beyond text length");

  // a dropped insert means the store is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && CapFits && (m_axis_tuser == STAT_FULL) |->
      m_axis_tdata[18:8] == CapLen)
    else $error("full status with room left");

endmodule

bind gap_buffer_text_store_top gbts_checker #(.CAPACITY(CAPACITY)) u_gbts_checker (.*);

/* dv/tb_gap_buffer_text_store_top.sv */
`timescale 1ns / 100ps

module tb_gap_buffer_text_store_top;
  import gbts_pkg::*;

  localparam int TEXT_CAP = DEFAULT_CAPACITY;
  localparam int POS_MAX  = (1 << POS_W) - 1;

  // one row of the directed edit script
  typedef struct {
    action_e          act;
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
    bit               typed;
    status_e          st;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] cur;
    logic [7:0]       rd;
  } edit_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // char_in[7:0], position[18:8], zero fill
  logic [1:0]  s_axis_tuser = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // char_out[7:0], text_length[18:8], cursor[29:19]
  logic [2:0]  m_axis_tuser;  // status[2:0]

  // mirror of the text store and its gap
  logic [7:0] text_mirror [TEXT_CAP];
  int         gap_lo = 0;
  int         gap_hi = TEXT_CAP;

  result_t awaited_reports [$];
  result_t seen_report;
  int      failures = 0;
  int      edits_sent = 0;
  bit      calm_mode = 1'b0;

  gap_buffer_text_store_top #(
    .CAPACITY(TEXT_CAP)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int text_len();
    return TEXT_CAP - (gap_hi - gap_lo);
  endfunction

  // apply one edit to the mirror and return the report it should give
  function automatic result_t apply_edit(action_e act, logic [7:0] ch, int pos);
    result_t res;
    int      span;
    res = '0;
    res.status = STAT_OK;
    case (act)
      ACT_INSERT: begin
        if (gap_lo >= gap_hi) begin
          res.status = STAT_FULL;
        end else begin
          text_mirror[gap_lo] = ch;
          gap_lo++;
        end
      end
      ACT_DELETE: begin
        if (gap_lo == 0) res.status = STAT_NODEL;
        else gap_lo--;
      end
      ACT_MOVE: begin
        if (pos > text_len()) begin
          res.status = STAT_BADMOVE;
        end else if (pos < gap_lo) begin
          // bytes left of the gap slide to its right end, top byte first
          span = gap_lo - pos;
          for (int k = span - 1; k >= 0; k--) text_mirror[gap_hi - span + k] = text_mirror[pos + k];
          gap_hi -= span;
          gap_lo = pos;
        end else if (pos > gap_lo) begin
          span = pos - gap_lo;
          for (int k = 0; k < span; k++) text_mirror[gap_lo + k] = text_mirror[gap_hi + k];
          gap_hi += span;
          gap_lo = pos;
        end
      end
      default: begin
        if (pos >= text_len()) res.status = STAT_RANGE;
        else res.char_out = text_mirror[(pos < gap_lo) ? pos : pos + gap_hi - gap_lo];
      end
    endcase
    res.text_length = POS_W'(text_len());
    res.cursor      = POS_W'(gap_lo);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hand one edit to the block and record the report it owes
  task automatic issue(input action_e act, input logic [7:0] ch, input logic [POS_W-1:0] pos,
                       input bit typed, input result_t typed_res);
    int      gap;
    result_t model_res;
    calm_mode = (edits_sent % 160) < 40;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'd0, pos, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    model_res = apply_edit(act, ch, int'(pos));
    awaited_reports.push_back(typed ? typed_res : model_res);
    edits_sent++;
  endtask

  // one random edit, weights in percent for insert, delete and move
  task automatic random_edit(input int w_ins, input int w_del, input int w_mov);
    int         r;
    int         len;
    int         pos;
    action_e    act;
    logic [7:0] ch;
    r   = $urandom_range(0, 99);
    len = text_len();
    ch  = 8'($urandom_range(0, 255));
    pos = $urandom_range(0, POS_MAX);
    if (r < w_ins) act = ACT_INSERT;
    else if (r < w_ins + w_del) act = ACT_DELETE;
    else if (r < w_ins + w_del + w_mov) act = ACT_MOVE;
    else act = ACT_READ;
    r = $urandom_range(0, 99);
    if (act == ACT_MOVE) begin
      if (r < 10) pos = $urandom_range(POS_MAX, len + 1);
      else if (r < 15) pos = len;
      else if (r < 20) pos = 0;
      else if (r < 25) pos = gap_lo;
      else pos = $urandom_range(len, 0);
    end else if (act == ACT_READ) begin
      if (r < 12 || len == 0) pos = $urandom_range(POS_MAX, len);
      else pos = $urandom_range(len - 1, 0);
    end
    issue(act, ch, POS_W'(pos), 1'b0, '0);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // result side: random stalls, with calm stretches held ready
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // check every result transaction against the oldest awaited report
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%h",
                 $time, m_axis_tdata, m_axis_tuser);
        failures++;
      end else begin
        seen_report = awaited_reports.pop_front();
        compare_field("char_out", seen_report.char_out, m_axis_tdata[7:0]);
        compare_field("text_length", seen_report.text_length, m_axis_tdata[18:8]);
        compare_field("cursor", seen_report.cursor, m_axis_tdata[29:19]);
        compare_field("status", seen_report.status, m_axis_tuser);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  // directed script, then random editing
  initial begin
    edit_row_t script [24];
    result_t   want;
    script = '{
      '{ACT_READ,   8'h00, 11'd0,    1, STAT_RANGE,   11'd0, 11'd0, 8'h00},
      '{ACT_DELETE, 8'h00, 11'd0,    1, STAT_NODEL,   11'd0, 11'd0, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd1,    1, STAT_BADMOVE, 11'd0, 11'd0, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd2047, 1, STAT_BADMOVE, 11'd0, 11'd0, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd0,    1, STAT_OK,      11'd0, 11'd0, 8'h00},
      '{ACT_INSERT, 8'h00, 11'd2047, 1, STAT_OK,      11'd1, 11'd1, 8'h00},
      '{ACT_INSERT, 8'hFF, 11'd0,    1, STAT_OK,      11'd2, 11'd2, 8'h00},
      '{ACT_INSERT, 8'hA5, 11'd0,    1, STAT_OK,      11'd3, 11'd3, 8'h00},
      '{ACT_READ,   8'h00, 11'd0,    1, STAT_OK,      11'd3, 11'd3, 8'h00},
      '{ACT_READ,   8'hFF, 11'd1,    1, STAT_OK,      11'd3, 11'd3, 8'hFF},
      '{ACT_READ,   8'h00, 11'd3,    1, STAT_RANGE,   11'd3, 11'd3, 8'h00},
      '{ACT_READ,   8'h00, 11'd2047, 1, STAT_RANGE,   11'd3, 11'd3, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd1,    1, STAT_OK,      11'd3, 11'd1, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd1,    1, STAT_OK,      11'd3, 11'd1, 8'h00},
      '{ACT_READ,   8'h00, 11'd2,    1, STAT_OK,      11'd3, 11'd1, 8'hA5},
      '{ACT_INSERT, 8'h5A, 11'd0,    1, STAT_OK,      11'd4, 11'd2, 8'h00},
      '{ACT_READ,   8'h00, 11'd1,    1, STAT_OK,      11'd4, 11'd2, 8'h5A},
      '{ACT_DELETE, 8'h00, 11'd0,    1, STAT_OK,      11'd3, 11'd1, 8'h00},
      '{ACT_DELETE, 8'hFF, 11'd2047, 1, STAT_OK,      11'd2, 11'd0, 8'h00},
      '{ACT_DELETE, 8'h00, 11'd0,    1, STAT_NODEL,   11'd2, 11'd0, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd3,    1, STAT_BADMOVE, 11'd2, 11'd0, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd2,    1, STAT_OK,      11'd2, 11'd2, 8'h00},
      '{ACT_READ,   8'h00, 11'd0,    0, STAT_OK,      11'd0, 11'd0, 8'h00},
      '{ACT_MOVE,   8'h00, 11'd0,    0, STAT_OK,      11'd0, 11'd0, 8'h00}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      want             = '0;
      want.status      = script[k].st;
      want.text_length = script[k].len;
      want.cursor      = script[k].cur;
      want.char_out    = script[k].rd;
      issue(script[k].act, script[k].ch, script[k].pos, script[k].typed, want);
    end

    // growth phase, mostly inserts with edits mixed in
    repeat (1300) random_edit(88, 2, 5);
    // fill to capacity, then push against the full buffer
    while (text_len() < TEXT_CAP) issue(ACT_INSERT, 8'($urandom_range(0, 255)), '0, 1'b0, '0);
    repeat (3) issue(ACT_INSERT, 8'($urandom_range(0, 255)), POS_W'($urandom_range(0, POS_MAX)),
                     1'b0, '0);
    random_edit(0, 0, 100);
    // shrink phase with heavy reading and moving
    repeat (550) random_edit(15, 35, 20);
    s_axis_tvalid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/gbts_pkg.sv
rtl/core/gbts_ram.sv
rtl/core/gbts_engine.sv
rtl/core/gap_buffer_text_store_top.sv
rtl/core/gbts_checker.sv
dv/tb_gap_buffer_text_store_top.sv
